// ----- rtl/core/mts_pkg.sv -----
// ---------------------------------------------------------------------------
// mts_pkg
// shared types and constants for the markov transition sampler
// ---------------------------------------------------------------------------
package mts_pkg;

    localparam int MTS_MAX_STATES         = 16;
    localparam int MTS_PROB_FRACTION_BITS = 16;
    localparam int MTS_UNIFORM_BITS       = 16;
    localparam int MTS_NUM_STATES_W       = 5;
    localparam int MTS_NUM_STATES_RESET   = 16;

    localparam logic MTS_ACT_LOAD    = 1'b0;
    localparam logic MTS_ACT_PREDICT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  entry_row;
        logic [3:0]  entry_column;
        logic [16:0] probability;
        logic [3:0]  current_state;
        logic [15:0] uniform_value;
    } mts_cmd_t;

    typedef struct packed {
        logic [3:0] next_state;
        logic       state_error;
    } mts_result_t;

    typedef enum logic {
        MTS_ST_IDLE,
        MTS_ST_SCAN
    } mts_state_t;

endpackage

// ----- rtl/core/mts_ram.sv -----
// ---------------------------------------------------------------------------
// mts_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/markov_transition_sampler_unit.sv -----
// ---------------------------------------------------------------------------
// markov_transition_sampler_unit
// draws the next state of a discrete markov chain by inverse transform sampling
// ---------------------------------------------------------------------------
// A load word writes one transition probability; busy stays low, so loads
// may arrive back to back. A predict word scans the cumulative row of
// current_state through one table read port and one comparator, one entry a
// cycle: it holds busy while it steps past or compares entries, at most
// num_states-1 of them, and its result appears on result with result_valid
// high for exactly one cycle, the cycle in which busy has just fallen. An
// out-of-range state, or a chain of one state, answers in the cycle after
// acceptance without a scan. The
// receiver cannot hold a result off: it must take result in the cycle
// result_valid is high.
// The table has no clearing pass; reading a never-written entry gives an
// undefined answer.
// ---------------------------------------------------------------------------
module markov_transition_sampler_unit #(
    parameter int MAX_STATES         = mts_pkg::MTS_MAX_STATES,
    parameter int PROB_FRACTION_BITS = mts_pkg::MTS_PROB_FRACTION_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mts_pkg::MTS_NUM_STATES_W-1:0]   cfg_wdata,
    input  logic                                   start,
    output logic                                   busy,
    input  mts_pkg::mts_cmd_t                      cmd,
    output logic                                   result_valid,
    output mts_pkg::mts_result_t                   result
);

    localparam int NW     = mts_pkg::MTS_NUM_STATES_W;
    localparam int PFB    = PROB_FRACTION_BITS;
    // cumulative values run 0 .. 1.0 inclusive
    localparam int PW     = PFB + 1;
    localparam int CAP_W  = (PW > 17) ? PW : 17;
    localparam int DEPTH  = MAX_STATES * MAX_STATES;
    localparam int ADDR_W = $clog2(DEPTH);
    // exact compare of u * 2^pfb against c * 2^16
    localparam int CMP_W  = PW + mts_pkg::MTS_UNIFORM_BITS;
    localparam logic [PW-1:0] PROB_ONE = {1'b1, {PFB{1'b0}}};

    // control and payload registers
    mts_pkg::mts_state_t  state_reg, state_next;
    logic [NW-1:0]        num_states_reg;
    logic [PW-1:0]        running_sum_reg, running_sum_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic [3:0]           cur_reg, cur_next;
    logic [15:0]          u_reg, u_next;
    mts_pkg::mts_result_t result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;

    // effective chain size, register value clamped into 1 .. MAX_STATES
    logic [NW-1:0] n_eff;
    always_comb
    begin
        priority if (num_states_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(num_states_reg) > MAX_STATES)
        begin
            n_eff = NW'(MAX_STATES);
        end
        else
        begin
            n_eff = num_states_reg;
        end
    end

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != mts_pkg::MTS_ST_IDLE);

    // load path: cap the probability, extend the running sum (restarted at column 0), saturate at one
    logic [CAP_W-1:0] prob_ext;
    logic [PW-1:0]    prob_cap;
    logic [PW:0]      sum_wide;
    logic [PW-1:0]    sum_load;
    logic             load_in_range;
    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;

    assign prob_ext = CAP_W'(cmd.probability);
    assign prob_cap = (prob_ext > CAP_W'(PROB_ONE)) ? PROB_ONE : prob_ext[PW-1:0];
    assign sum_wide = {1'b0, running_sum_reg} + {1'b0, prob_cap};

    always_comb
    begin
        if (cmd.entry_column == 4'd0)
        begin
            sum_load = prob_cap;
        end
        else if (sum_wide > {1'b0, PROB_ONE})
        begin
            sum_load = PROB_ONE;
        end
        else
        begin
            sum_load = sum_wide[PW-1:0];
        end
    end

    assign load_in_range = ({1'b0, cmd.entry_row} < n_eff)
                        && ({1'b0, cmd.entry_column} < n_eff);
    assign ram_we    = accept && (cmd.action == mts_pkg::MTS_ACT_LOAD) && load_in_range;
    assign ram_waddr = ADDR_W'(int'(cmd.entry_row) * MAX_STATES + int'(cmd.entry_column));

    // scan path: one table read and one compare each cycle
    logic [ADDR_W-1:0] ram_raddr;
    logic [PW-1:0]     ram_rdata;
    logic [NW-1:0]     idx_inc;
    logic [NW-1:0]     last_idx;
    logic              step_past;

    assign idx_inc   = idx_reg + NW'(1);
    assign last_idx  = n_eff - NW'(1);
    assign step_past = ((CMP_W'(u_reg) << PFB)
                       > (CMP_W'(ram_rdata) << mts_pkg::MTS_UNIFORM_BITS));

    mts_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sum_load),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cur_next          = cur_reg;
        u_next            = u_reg;
        running_sum_next  = running_sum_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        // idle reads column 0 of the requested row, scan reads the next column
        ram_raddr = ADDR_W'(int'(cmd.current_state) * MAX_STATES);

        unique case (state_reg)
            mts_pkg::MTS_ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == mts_pkg::MTS_ACT_LOAD)
                    begin
                        if (load_in_range)
                        begin
                            running_sum_next = sum_load;
                        end
                    end
                    else if ({1'b0, cmd.current_state} >= n_eff)
                    begin
                        // state outside the chain
                        result_next.next_state  = 4'd0;
                        result_next.state_error = 1'b1;
                        result_valid_next       = 1'b1;
                    end
                    else if (last_idx == '0)
                    begin
                        // one-state chain, nothing to scan
                        result_next.next_state  = 4'd0;
                        result_next.state_error = 1'b0;
                        result_valid_next       = 1'b1;
                    end
                    else
                    begin
                        cur_next   = cmd.current_state;
                        u_next     = cmd.uniform_value;
                        idx_next   = '0;
                        state_next = mts_pkg::MTS_ST_SCAN;
                    end
                end
            end

            mts_pkg::MTS_ST_SCAN:
            begin
                ram_raddr = ADDR_W'(int'(cur_reg) * MAX_STATES + int'(idx_inc));
                result_next.state_error = 1'b0;
                if (step_past && (idx_inc < last_idx))
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    // stop here, or one past when the last column is reached
                    result_next.next_state = step_past ? idx_inc[3:0] : idx_reg[3:0];
                    result_valid_next      = 1'b1;
                    state_next             = mts_pkg::MTS_ST_IDLE;
                end
            end

            default:
            begin
                state_next = mts_pkg::MTS_ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mts_pkg::MTS_ST_IDLE;
            num_states_reg   <= NW'(mts_pkg::MTS_NUM_STATES_RESET);
            running_sum_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            running_sum_reg  <= running_sum_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                num_states_reg <= cfg_wdata;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        u_reg      <= u_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
